[sv/cdcs_pkg.sv]
// Shared types, constants and the sigmoid table for the causal depthwise conv block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cdcs_pkg;

    // Default sizing, handed to the top level parameters
    localparam int CHANNELS_DEF    = 64;
    localparam int MAX_TAPS_DEF    = 4;
    localparam int MAX_SPACING_DEF = 4;

    // Transaction field widths
    localparam int OPCODE_W  = 2;
    localparam int CHANNEL_W = 6;
    localparam int TAP_W     = 2;
    localparam int VALUE_W   = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_WEIGHT = 2'd1,
        OP_BIAS   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // APB register file
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_TAPS    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SPACING = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SILU    = 2'd2;

    localparam int TAPS_W    = 3;
    localparam int SPACING_W = 3;
    localparam logic [TAPS_W-1:0]    TAPS_RST    = 3'd4;
    localparam logic [SPACING_W-1:0] SPACING_RST = 3'd1;

    typedef struct packed {
        logic [TAPS_W-1:0]    taps_in_use;
        logic [SPACING_W-1:0] tap_spacing;
        logic                 silu_enable;
    } cfg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_WIPE,
        ST_PREP,
        ST_ISSUE,
        ST_MUL,
        ST_ACC,
        ST_ROUND,
        ST_SIG,
        ST_SIGADD,
        ST_SILU,
        ST_SHIFT,
        ST_OUT
    } state_t;

    // Datapath widths
    localparam int ACC_W      = 40;           // Q.25 accumulator
    localparam int ACC_FRAC   = 14;           // Q.25 -> Q4.11
    localparam int Y_W        = ACC_W - ACC_FRAC;
    localparam int MUL_A_W    = Y_W;
    localparam int MUL_B_W    = 17;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int SILU_SHIFT = 15;
    localparam int Z_W        = MUL_P_W - SILU_SHIFT;
    localparam int SIG_W      = 15;
    localparam int SIG_U_W    = 16;
    localparam int SIG_IDX_W  = 6;
    localparam int SIG_FRAC_W = 10;

    localparam logic signed [ACC_W-1:0]   ROUND_HALF  = 40'sd8192;
    localparam logic signed [MUL_P_W-1:0] SILU_HALF   = 43'sd16384;
    localparam logic signed [Y_W-1:0]     SIG_X_MIN   = -26'sd16384;
    localparam logic signed [Y_W-1:0]     SIG_X_MAX   = 26'sd16384;
    localparam logic signed [Y_W-1:0]     SIG_OFFSET  = 26'sd16384;
    localparam logic [SIG_U_W-1:0]        SIG_U_MAX   = 16'd32768;
    localparam logic signed [Z_W-1:0]     OUT_MAX     = 28'sd32767;
    localparam logic signed [Z_W-1:0]     OUT_MIN     = -28'sd32768;
    localparam logic signed [VALUE_W-1:0] OUT_MAX_16  = 16'sh7FFF;
    localparam logic signed [VALUE_W-1:0] OUT_MIN_16  = 16'sh8000;

    // Sigmoid in Q0.15 at half-unit steps from -8 to +8; beyond the end holds the top
    function automatic logic [SIG_W-1:0] sig_point(input logic [SIG_IDX_W-1:0] idx);
        case (idx)
            6'd0:    return 15'd11;
            6'd1:    return 15'd18;
            6'd2:    return 15'd30;
            6'd3:    return 15'd49;
            6'd4:    return 15'd81;
            6'd5:    return 15'd133;
            6'd6:    return 15'd219;
            6'd7:    return 15'd360;
            6'd8:    return 15'd589;
            6'd9:    return 15'd961;
            6'd10:   return 15'd1554;
            6'd11:   return 15'd2486;
            6'd12:   return 15'd3906;
            6'd13:   return 15'd5978;
            6'd14:   return 15'd8813;
            6'd15:   return 15'd12371;
            6'd16:   return 15'd16384;
            6'd17:   return 15'd20397;
            6'd18:   return 15'd23955;
            6'd19:   return 15'd26790;
            6'd20:   return 15'd28862;
            6'd21:   return 15'd30282;
            6'd22:   return 15'd31214;
            6'd23:   return 15'd31807;
            6'd24:   return 15'd32179;
            6'd25:   return 15'd32408;
            6'd26:   return 15'd32549;
            6'd27:   return 15'd32635;
            6'd28:   return 15'd32687;
            6'd29:   return 15'd32719;
            6'd30:   return 15'd32738;
            6'd31:   return 15'd32750;
            6'd32:   return 15'd32757;
            default: return 15'd32757;
        endcase
    endfunction

endpackage

`default_nettype wire

[sv/cdcs_if.sv]
// Stream interfaces: input item channel and result channel (valid/ready).
// Depends on cdcs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cdcs_item_if
    import cdcs_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [OPCODE_W-1:0]         opcode;
    logic [CHANNEL_W-1:0]        channel;
    logic [TAP_W-1:0]            tap_index;
    logic signed [VALUE_W-1:0]   value;

    modport source (output valid, opcode, channel, tap_index, value, input ready);
    modport sink   (input valid, opcode, channel, tap_index, value, output ready);
endinterface

interface cdcs_result_if
    import cdcs_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [CHANNEL_W-1:0]        out_channel;
    logic signed [VALUE_W-1:0]   out_value;
    logic                        saturated;

    modport source (output valid, out_channel, out_value, saturated, input ready);
    modport sink   (input valid, out_channel, out_value, saturated, output ready);
endinterface

`default_nettype wire

[sv/cdcs_regs.sv]
// APB configuration registers: taps_in_use, tap_spacing, silu_enable.
// Depends on cdcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdcs_regs
    import cdcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.taps_in_use <= TAPS_RST;
            cfg_reg.tap_spacing <= SPACING_RST;
            cfg_reg.silu_enable <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_TAPS:    cfg_reg.taps_in_use <= pwdata[TAPS_W-1:0];
                REG_SPACING: cfg_reg.tap_spacing <= pwdata[SPACING_W-1:0];
                REG_SILU:    cfg_reg.silu_enable <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TAPS:    prdata = PDATA_W'(cfg_reg.taps_in_use);
            REG_SPACING: prdata = PDATA_W'(cfg_reg.tap_spacing);
            REG_SILU:    prdata = PDATA_W'(cfg_reg.silu_enable);
            default:     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[sv/causal_depthwise_conv_with_state.sv]
// Top level: per-channel dilated causal FIR with stored history and optional SiLU.
// Depends on cdcs_pkg, cdcs_if (item and result interfaces) and cdcs_regs.
`timescale 1ns / 1ps
`default_nettype none

//  channel   direction  carries                                    handshake
//  item      in         opcode, channel, tap_index, value          valid/ready
//  result    out        out_channel, out_value, saturated          valid/ready
//  apb       in/out     taps_in_use, tap_spacing, silu_enable      psel/penable, pready=1
//
//  A sample transaction takes each of the K taps in use through read, multiply,
//  accumulate on the one shared multiplier, and no next item is taken before it
//  finishes. After reset a clearing pass zeroes history, heads and biases; no
//  item is taken meanwhile, register writes are. A finished result sits in the
//  output register, so the next item is accepted while it waits; only the
//  following result stalls.

module causal_depthwise_conv_with_state
    import cdcs_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int MAX_TAPS    = MAX_TAPS_DEF,
    parameter int MAX_SPACING = MAX_SPACING_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    cdcs_item_if.sink          item,
    cdcs_result_if.source      result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // ------------------------------------------------------------------
    // Sizing
    // ------------------------------------------------------------------
    localparam int HIST_LEN   = (MAX_TAPS - 1) * MAX_SPACING;
    localparam int HIST_DEPTH = CHANNELS * HIST_LEN;
    localparam int W_DEPTH    = CHANNELS * MAX_TAPS;
    localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HL_W       = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
    localparam int AGE_W      = $clog2(HIST_LEN + 1);
    localparam int SW         = AGE_W + 1;
    localparam int HA_W       = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int WA_W       = $clog2(W_DEPTH);
    localparam int TW         = $clog2(MAX_TAPS);
    localparam int KW         = $clog2(MAX_TAPS + 1);
    localparam int DW         = $clog2(MAX_SPACING + 1);

    localparam logic [HA_W-1:0] CLR_LAST  = HA_W'(HIST_DEPTH - 1);
    localparam logic [HA_W-1:0] WIPE_LAST = HA_W'(HIST_LEN - 1);
    localparam logic [HL_W-1:0] HEAD_LAST = HL_W'(HIST_LEN - 1);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    cfg_t cfg;

    cdcs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Register values out of range clamp to 1..max
    logic [7:0]    k_wide, d_wide, k_clamp, d_clamp;
    logic [KW-1:0] k_eff;
    logic [DW-1:0] d_eff;
    logic [TW-1:0] k_init;

    always_comb
    begin
        k_wide = 8'(cfg.taps_in_use);
        d_wide = 8'(cfg.tap_spacing);
        if (k_wide == 8'd0)
            k_clamp = 8'd1;
        else if (k_wide > 8'(MAX_TAPS))
            k_clamp = 8'(MAX_TAPS);
        else
            k_clamp = k_wide;
        if (d_wide == 8'd0)
            d_clamp = 8'd1;
        else if (d_wide > 8'(MAX_SPACING))
            d_clamp = 8'(MAX_SPACING);
        else
            d_clamp = d_wide;
        k_eff  = KW'(k_clamp);
        d_eff  = DW'(d_clamp);
        k_init = TW'(k_eff - KW'(1));
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                     state_reg, state_next;
    logic [HA_W-1:0]            sweep_reg;
    logic                       out_valid_reg;

    op_t                        op_reg;
    logic [CHANNEL_W-1:0]       ch_reg;
    logic [TAP_W-1:0]           tap_reg;
    logic signed [VALUE_W-1:0]  val_reg;
    logic [HA_W-1:0]            hist_base_reg;
    logic [WA_W-1:0]            w_base_reg;
    logic [HL_W-1:0]            head_reg;
    logic [TW-1:0]              k_reg;
    logic [AGE_W-1:0]           age_reg;
    logic                       first_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [MUL_P_W-1:0]  prod_reg;
    logic signed [Y_W-1:0]      y_reg;
    logic signed [Z_W-1:0]      z_reg;
    logic [SIG_W-1:0]           sig_base_reg;
    logic [SIG_W-1:0]           sig_reg;

    logic [CHANNEL_W-1:0]       out_channel_reg;
    logic signed [VALUE_W-1:0]  out_value_reg;
    logic                       out_sat_reg;

    // ------------------------------------------------------------------
    // Memories: history, head pointers, biases, weights
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0]  hist_mem [HIST_DEPTH];
    logic [HL_W-1:0]            head_mem [CHANNELS];
    logic signed [VALUE_W-1:0]  bias_mem [CHANNELS];
    logic signed [VALUE_W-1:0]  w_mem    [W_DEPTH];

    logic signed [VALUE_W-1:0]  hist_rd_reg;
    logic [HL_W-1:0]            head_rd_reg;
    logic signed [VALUE_W-1:0]  bias_rd_reg;
    logic signed [VALUE_W-1:0]  w_rd_reg;

    logic                       hist_we, head_we, bias_we, w_we;
    logic [HA_W-1:0]            hist_waddr, hist_raddr;
    logic signed [VALUE_W-1:0]  hist_wdata, bias_wdata;
    logic [CH_AW-1:0]           head_waddr, bias_waddr, ch_idx;
    logic [HL_W-1:0]            head_wdata;
    logic [WA_W-1:0]            w_waddr, w_raddr;

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic                       ch_ok, tap_ok, sweep_in_ch, out_free, out_load;
    logic [SW-1:0]              slot_diff, slot_wrap;
    logic [HL_W-1:0]            slot, head_inc;

    assign ch_ok       = int'(ch_reg) < CHANNELS;
    assign tap_ok      = int'(tap_reg) < MAX_TAPS;
    assign sweep_in_ch = int'(sweep_reg) < CHANNELS;
    assign ch_idx      = CH_AW'(ch_reg);
    assign out_free    = !out_valid_reg || result.ready;

    // Slot of the sample age_reg steps back, wrapping round the circular history
    assign slot_diff = SW'(head_reg) - SW'(age_reg);
    assign slot_wrap = slot_diff[SW-1] ? slot_diff + SW'(HIST_LEN) : slot_diff;
    assign slot      = HL_W'(slot_wrap);
    assign head_inc  = (head_reg == HEAD_LAST) ? '0 : head_reg + 1'b1;

    assign hist_raddr = hist_base_reg + HA_W'(slot);
    assign w_raddr    = w_base_reg + WA_W'(k_reg);

    // Rounding Q.25 -> Q4.11, floor after adding half
    logic signed [ACC_W-1:0]    round_sum;
    logic signed [Y_W-1:0]      y_round;
    assign round_sum = acc_reg + ROUND_HALF;
    assign y_round   = round_sum[ACC_W-1:ACC_FRAC];

    // SiLU output rounding
    logic signed [MUL_P_W-1:0]  silu_sum;
    assign silu_sum = prod_reg + SILU_HALF;

    // Sigmoid table lookup from the clamped pre-activation
    logic signed [Y_W-1:0]      sig_sum;
    logic [SIG_U_W-1:0]         sig_u;
    logic [SIG_IDX_W-1:0]       sig_idx;
    logic [SIG_FRAC_W-1:0]      sig_frac;
    logic [SIG_W-1:0]           sig_lo, sig_hi, sig_diff;

    always_comb
    begin
        sig_sum = y_reg + SIG_OFFSET;
        if (y_reg < SIG_X_MIN)
            sig_u = '0;
        else if (y_reg > SIG_X_MAX)
            sig_u = SIG_U_MAX;
        else
            sig_u = sig_sum[SIG_U_W-1:0];
        sig_idx  = sig_u[SIG_U_W-1:SIG_FRAC_W];
        sig_frac = sig_u[SIG_FRAC_W-1:0];
        sig_lo   = sig_point(sig_idx);
        sig_hi   = sig_point(sig_idx + 6'd1);
        sig_diff = sig_hi - sig_lo;
    end

    // Output saturation
    logic                       sat_flag;
    logic signed [VALUE_W-1:0]  sat_value;

    always_comb
    begin
        if (z_reg > OUT_MAX)
        begin
            sat_flag  = 1'b1;
            sat_value = OUT_MAX_16;
        end
        else if (z_reg < OUT_MIN)
        begin
            sat_flag  = 1'b1;
            sat_value = OUT_MIN_16;
        end
        else
        begin
            sat_flag  = 1'b0;
            sat_value = z_reg[VALUE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:   if (sweep_reg == CLR_LAST) state_next = ST_IDLE;
            ST_IDLE:   if (item.valid) state_next = ST_DECODE;
            ST_DECODE:
            begin
                if (!ch_ok)
                    state_next = ST_IDLE;
                else
                begin
                    case (op_reg)
                        OP_SAMPLE: state_next = ST_PREP;
                        OP_CLEAR:  state_next = ST_WIPE;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WIPE:   if (sweep_reg == WIPE_LAST) state_next = ST_IDLE;
            ST_PREP:   state_next = ST_ISSUE;
            ST_ISSUE:  state_next = ST_MUL;
            ST_MUL:    state_next = ST_ACC;
            ST_ACC:    state_next = (k_reg == '0) ? ST_ROUND : ST_ISSUE;
            ST_ROUND:  state_next = cfg.silu_enable ? ST_SIG : ST_OUT;
            ST_SIG:    state_next = ST_SIGADD;
            ST_SIGADD: state_next = ST_SILU;
            ST_SILU:   state_next = ST_SHIFT;
            ST_SHIFT:  state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs (memory strobes, multiplier operands)
    // ------------------------------------------------------------------
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;

    always_comb
    begin
        item.ready = 1'b0;
        hist_we    = 1'b0;
        hist_waddr = sweep_reg;
        hist_wdata = '0;
        head_we    = 1'b0;
        head_waddr = ch_idx;
        head_wdata = '0;
        bias_we    = 1'b0;
        bias_waddr = ch_idx;
        bias_wdata = '0;
        w_we       = 1'b0;
        w_waddr    = w_base_reg + WA_W'(tap_reg);
        mul_a      = '0;
        mul_b      = '0;
        out_load   = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                hist_we    = 1'b1;
                head_we    = sweep_in_ch;
                head_waddr = CH_AW'(sweep_reg);
                bias_we    = sweep_in_ch;
                bias_waddr = CH_AW'(sweep_reg);
            end
            ST_IDLE:
                item.ready = 1'b1;
            ST_DECODE:
            begin
                if (ch_ok)
                begin
                    case (op_reg)
                        OP_WEIGHT: w_we = tap_ok;
                        OP_BIAS:
                        begin
                            bias_we    = 1'b1;
                            bias_wdata = val_reg;
                        end
                        OP_CLEAR:  head_we = 1'b1;
                        default:   ;
                    endcase
                end
            end
            ST_WIPE:
            begin
                hist_we    = 1'b1;
                hist_waddr = hist_base_reg + sweep_reg;
            end
            ST_MUL:
            begin
                // the newest tap takes the incoming sample, older ones the history
                mul_a = MUL_A_W'(w_rd_reg);
                mul_b = MUL_B_W'(first_reg ? val_reg : hist_rd_reg);
            end
            ST_SIG:
            begin
                mul_a = MUL_A_W'(sig_diff);
                mul_b = MUL_B_W'(sig_frac);
            end
            ST_SILU:
            begin
                mul_a = y_reg;
                mul_b = MUL_B_W'(sig_reg);
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    hist_we    = 1'b1;
                    hist_waddr = hist_base_reg + HA_W'(head_reg);
                    hist_wdata = val_reg;
                    head_we    = 1'b1;
                    head_wdata = head_inc;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_INIT, ST_WIPE: sweep_reg <= sweep_reg + 1'b1;
                ST_DECODE:        sweep_reg <= '0;
                default:          ;
            endcase
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers and the shared multiplier
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (item.valid && item.ready)
        begin
            op_reg        <= op_t'(item.opcode);
            ch_reg        <= item.channel;
            tap_reg       <= item.tap_index;
            val_reg       <= item.value;
            hist_base_reg <= HA_W'(item.channel) * HA_W'(HIST_LEN);
            w_base_reg    <= WA_W'(item.channel) * WA_W'(MAX_TAPS);
        end

        case (state_reg)
            ST_PREP:
            begin
                head_reg  <= head_rd_reg;
                acc_reg   <= ACC_W'(bias_rd_reg) <<< ACC_FRAC;
                k_reg     <= k_init;
                age_reg   <= '0;
                first_reg <= 1'b1;
            end
            ST_ACC:
            begin
                acc_reg   <= acc_reg + ACC_W'(prod_reg);
                k_reg     <= k_reg - 1'b1;
                age_reg   <= age_reg + AGE_W'(d_eff);
                first_reg <= 1'b0;
            end
            ST_ROUND:
            begin
                y_reg <= y_round;
                z_reg <= Z_W'(y_round);
            end
            ST_SIG:    sig_base_reg <= sig_lo;
            ST_SIGADD: sig_reg <= sig_base_reg + prod_reg[SIG_W+SIG_FRAC_W-1:SIG_FRAC_W];
            ST_SHIFT:  z_reg <= silu_sum[MUL_P_W-1:SILU_SHIFT];
            default:   ;
        endcase

        if (out_load)
        begin
            out_channel_reg <= ch_reg;
            out_value_reg   <= sat_value;
            out_sat_reg     <= sat_flag;
        end
    end

    // Memory ports: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_waddr] <= hist_wdata;
        hist_rd_reg <= hist_mem[hist_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_waddr] <= head_wdata;
        head_rd_reg <= head_mem[ch_idx];
    end

    always_ff @(posedge clk)
    begin
        if (bias_we)
            bias_mem[bias_waddr] <= bias_wdata;
        bias_rd_reg <= bias_mem[ch_idx];
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
            w_mem[w_waddr] <= val_reg;
        w_rd_reg <= w_mem[w_raddr];
    end

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------
    assign result.valid       = out_valid_reg;
    assign result.out_channel = out_channel_reg;
    assign result.out_value   = out_value_reg;
    assign result.saturated   = out_sat_reg;

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for causal_depthwise_conv_with_state: directed and random
// transactions, an APB register port and a scoreboard that predicts every result.
// Depends on cdcs_pkg, cdcs_if and the block's RTL.
`timescale 1ns / 1ps

module testbench;
    import cdcs_pkg::*;

    localparam int N_CH         = CHANNELS_DEF;
    localparam int N_TAPS       = MAX_TAPS_DEF;
    localparam int N_SPACING    = MAX_SPACING_DEF;
    localparam int HIST_DEPTH   = (N_TAPS - 1) * N_SPACING;

    // The longest internal job is a SiLU sample at the full tap count.
    // Wait well past it before touching the registers.
    localparam int SETTLE_CYCLES   = 40;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int HOLD_OFF_CYCLES = 300;

    // Fixed settings for the first random phases (K, d, SiLU); later ones are random.
    // 0 and values above the maximum are deliberate: they must clamp.
    localparam int FIXED_PHASES = 7;
    localparam int PHASE_TAPS [FIXED_PHASES]    = '{4, 1, 1, 2, 0, 7, 3};
    localparam int PHASE_SPACING [FIXED_PHASES] = '{4, 1, 4, 3, 0, 7, 2};
    localparam int PHASE_SILU [FIXED_PHASES]    = '{1, 0, 1, 0, 1, 0, 1};

    // Sigmoid in Q0.15, half-unit steps from -8 to +8
    localparam int SIG_LUT [33] = '{
        11, 18, 30, 49, 81, 133, 219, 360, 589, 961, 1554,
        2486, 3906, 5978, 8813, 12371, 16384, 20397, 23955, 26790, 28862,
        30282, 31214, 31807, 32179, 32408, 32549, 32635, 32687, 32719, 32738,
        32750, 32757};

    typedef struct packed {
        logic [CHANNEL_W-1:0]      ch;
        logic signed [VALUE_W-1:0] value;
        logic                      sat;
    } conv_out_t;

    // ------------------------------------------------------------------
    // Scoreboard: private copy of filter state, queue of expected results
    // ------------------------------------------------------------------
    class conv_scoreboard;
        logic [TAPS_W-1:0]         taps_reg;
        logic [SPACING_W-1:0]      spacing_reg;
        logic                      silu_reg;
        logic signed [VALUE_W-1:0] history [N_CH][HIST_DEPTH];
        int unsigned               head [N_CH];
        logic signed [VALUE_W-1:0] weights [N_CH][N_TAPS];
        bit                        weight_loaded [N_CH][N_TAPS];
        logic signed [VALUE_W-1:0] bias [N_CH];
        conv_out_t                 pending_outputs [$];
        int                        errors;

        function new();
            taps_reg    = TAPS_RST;
            spacing_reg = SPACING_RST;
            silu_reg    = 1'b0;
            errors      = 0;
            foreach (history[c, s]) history[c][s] = '0;
            foreach (head[c]) head[c] = 0;
            foreach (weights[c, t])
            begin
                weights[c][t]       = '0;
                weight_loaded[c][t] = 1'b0;
            end
            foreach (bias[c]) bias[c] = '0;
        endfunction

        function int eff_taps();
            if (taps_reg == 0) return 1;
            if (taps_reg > N_TAPS) return N_TAPS;
            return int'(taps_reg);
        endfunction

        function int eff_spacing();
            if (spacing_reg == 0) return 1;
            if (spacing_reg > N_SPACING) return N_SPACING;
            return int'(spacing_reg);
        endfunction

        // x in Q4.11, clamped to +-8, linear interpolation with floor
        function longint sigmoid_q15(longint x);
            longint      c;
            int unsigned u;
            int unsigned idx;
            int unsigned frac;
            c = x;
            if (c < -16384) c = -16384;
            if (c > 16384) c = 16384;
            u    = int'(c + 16384);
            idx  = u >> 10;
            frac = u & 1023;
            if (idx >= 32) return SIG_LUT[32];
            return SIG_LUT[idx] + (((SIG_LUT[idx+1] - SIG_LUT[idx]) * frac) >> 10);
        endfunction

        function conv_out_t filter_sample(int ch, logic signed [VALUE_W-1:0] sample);
            int        k_use;
            int        d_use;
            int        slot;
            longint    acc;
            longint    y;
            conv_out_t res;
            k_use = eff_taps();
            d_use = eff_spacing();
            acc   = longint'(bias[ch]) * 16384;
            for (int k = 0; k + 1 < k_use; k++)
            begin
                slot = (head[ch] + HIST_DEPTH - (k_use - 1 - k) * d_use) % HIST_DEPTH;
                acc += longint'(weights[ch][k]) * longint'(history[ch][slot]);
            end
            acc += longint'(weights[ch][k_use-1]) * longint'(sample);
            y = (acc + 8192) >>> 14;
            if (silu_reg) y = (y * sigmoid_q15(y) + 16384) >>> 15;
            res.sat = 1'b0;
            if (y > 32767)
            begin
                y       = 32767;
                res.sat = 1'b1;
            end
            if (y < -32768)
            begin
                y       = -32768;
                res.sat = 1'b1;
            end
            res.value = y[VALUE_W-1:0];
            res.ch    = ch[CHANNEL_W-1:0];
            history[ch][head[ch]] = sample;
            head[ch] = (head[ch] + 1) % HIST_DEPTH;
            return res;
        endfunction

        function void note_item(op_t op, logic [CHANNEL_W-1:0] ch, logic [TAP_W-1:0] tap,
                                logic signed [VALUE_W-1:0] val);
            case (op)
                OP_SAMPLE: pending_outputs.push_back(filter_sample(int'(ch), val));
                OP_WEIGHT:
                begin
                    weights[ch][tap]       = val;
                    weight_loaded[ch][tap] = 1'b1;
                end
                OP_BIAS:   bias[ch] = val;
                OP_CLEAR:
                begin
                    for (int s = 0; s < HIST_DEPTH; s++) history[ch][s] = '0;
                    head[ch] = 0;
                end
            endcase
        endfunction

        function void check_result(conv_out_t got);
            conv_out_t exp_out;
            if (pending_outputs.size() == 0)
            begin
                $error("unexpected result: out_channel %0d out_value %0d saturated %0b",
                       got.ch, got.value, got.sat);
                errors++;
                return;
            end
            exp_out = pending_outputs.pop_front();
            if (got.ch !== exp_out.ch)
            begin
                $error("out_channel: expected %0d, actual %0d", exp_out.ch, got.ch);
                errors++;
            end
            if (got.value !== exp_out.value)
            begin
                $error("out_value: expected %0d, actual %0d", exp_out.value, got.value);
                errors++;
            end
            if (got.sat !== exp_out.sat)
            begin
                $error("saturated: expected %0b, actual %0b", exp_out.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, channels, block
    // ------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    cdcs_item_if   item_ch ();
    cdcs_result_if result_ch ();

    conv_scoreboard sb;
    bit             hold_req;     // main flow asks the receiver for a long hold-off
    bit             valid_up;     // sender currently has valid raised
    int             burst_left;   // transactions left in the current sender burst

    causal_depthwise_conv_with_state dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------

    // APB write: setup cycle, then access until pready. Ends on an idle cycle so
    // that back-to-back writes never schedule two updates of psel in one step.
    task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_TAPS)
            sb.taps_reg = data[TAPS_W-1:0];
        else if (idx == REG_SPACING)
            sb.spacing_reg = data[SPACING_W-1:0];
        else if (idx == REG_SILU)
            sb.silu_reg = data[0];
        @(posedge clk);
    endtask

    task automatic set_config(int k, int d, int silu);
        reg_write(REG_TAPS, k);
        reg_write(REG_SPACING, d);
        reg_write(REG_SILU, silu);
    endtask

    // Present one transaction and hold it until the block takes it. Valid stays
    // high on return; pacing decides whether it drops in this same step.
    task automatic offer(op_t op, logic [CHANNEL_W-1:0] ch, logic [TAP_W-1:0] tap,
                         logic signed [VALUE_W-1:0] val);
        item_ch.valid     <= 1'b1;
        item_ch.opcode    <= op;
        item_ch.channel   <= ch;
        item_ch.tap_index <= tap;
        item_ch.value     <= val;
        valid_up = 1'b1;
        do @(posedge clk); while (item_ch.ready !== 1'b1);
        sb.note_item(op, ch, tap, val);
    endtask

    // Sender pacing: bursts of random length, long ones now and then, random gaps
    task automatic send(op_t op, logic [CHANNEL_W-1:0] ch, logic [TAP_W-1:0] tap,
                        logic signed [VALUE_W-1:0] val);
        int gap;
        offer(op, ch, tap, val);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(1, 12);
            item_ch.valid <= 1'b0;
            valid_up = 1'b0;
            repeat (gap) @(posedge clk);
        end
        else
            burst_left--;
    endtask

    // Let every expected result arrive, then let any trailing load or clear finish
    task automatic drain();
        if (valid_up)
        begin
            item_ch.valid <= 1'b0;
            valid_up = 1'b0;
        end
        while (sb.pending_outputs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly mid-range values so SiLU sweeps its table; extremes and full noise too
    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return VALUE_W'($urandom_range(0, 511) - 256);
            3:       return VALUE_W'($urandom);
            default: return VALUE_W'($urandom_range(0, 8191) - 4096);
        endcase
    endfunction

    // Random transaction, mostly samples on a handful of channels so that the
    // histories run deep. A sample on a channel whose active weights are not all
    // loaded yet becomes a load of the lowest missing tap.
    task automatic random_item();
        int                        pick;
        op_t                       op;
        logic [CHANNEL_W-1:0]      ch;
        logic [TAP_W-1:0]          tap;
        logic signed [VALUE_W-1:0] val;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 3) != 0)
            ch = CHANNEL_W'($urandom_range(0, 3));
        else
            ch = CHANNEL_W'($urandom_range(0, N_CH - 1));
        tap = TAP_W'($urandom);
        val = rand_value();
        if (pick < 72)
            op = OP_SAMPLE;
        else if (pick < 84)
            op = OP_WEIGHT;
        else if (pick < 94)
            op = OP_BIAS;
        else
            op = OP_CLEAR;
        if (op == OP_SAMPLE)
        begin
            for (int t = sb.eff_taps() - 1; t >= 0; t--)
            begin
                if (!sb.weight_loaded[ch][t])
                begin
                    op  = OP_WEIGHT;
                    tap = TAP_W'(t);
                end
            end
        end
        send(op, ch, tap, val);
    endtask

    // ------------------------------------------------------------------
    // Receiver: checks each result transaction, stalls on its own pattern
    // (segments of fixed stall density, none to heavy) plus long hold-offs
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int        seg_left;
        int        stall_pct;
        int        hold_left;
        conv_out_t got;
        result_ch.ready = 1'b0;
        seg_left  = 0;
        stall_pct = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                got.ch    = result_ch.out_channel;
                got.value = result_ch.out_value;
                got.sat   = result_ch.saturated;
                sb.check_result(got);
            end
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(8, 64);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            seg_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(1, 100) > stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Main flow
    // ------------------------------------------------------------------
    initial
    begin : main_flow
        int k;
        int d;
        int silu;
        sb                = new();
        hold_req          = 1'b0;
        valid_up          = 1'b0;
        burst_left        = 0;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        item_ch.valid     = 1'b0;
        item_ch.opcode    = OP_SAMPLE;
        item_ch.channel   = '0;
        item_ch.tap_index = '0;
        item_ch.value     = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Registers may be written during the post-reset clearing pass; the block
        // only holds off transactions then.
        set_config(4, 1, 0);

        // Directed: extreme weights and bias on channel 0, so both saturation
        // directions show up as the history fills
        send(OP_WEIGHT, 0, 0, 16'sd16384);
        send(OP_WEIGHT, 0, 1, 16'sh8000);
        send(OP_WEIGHT, 0, 2, 16'sh7FFF);
        send(OP_WEIGHT, 0, 3, 16'sd16384);
        send(OP_BIAS,   0, 0, 16'sh7FFF);
        send(OP_SAMPLE, 0, 0, 16'sh7FFF);
        send(OP_SAMPLE, 0, 1, 16'sh8000);
        send(OP_SAMPLE, 0, 2, 16'sh7FFF);
        send(OP_SAMPLE, 0, 3, 16'sd0);
        send(OP_BIAS,   0, 3, 16'sh8000);
        send(OP_SAMPLE, 0, 2, 16'sh8000);
        send(OP_SAMPLE, 0, 1, -16'sd1);
        // Top channel: most negative weights, bias still at its reset zero
        send(OP_WEIGHT, 63, 0, 16'sh8000);
        send(OP_WEIGHT, 63, 1, 16'sh8000);
        send(OP_WEIGHT, 63, 2, 16'sh8000);
        send(OP_WEIGHT, 63, 3, 16'sh8000);
        send(OP_SAMPLE, 63, 3, 16'sh7FFF);
        send(OP_SAMPLE, 63, 0, 16'sh8000);
        // Clearing a history: the next sample sees zeros behind it
        send(OP_CLEAR,  63, 2, 16'sh7FFF);
        send(OP_SAMPLE, 63, 1, 16'sd1);
        send(OP_CLEAR,  0, 0, 16'sd0);
        send(OP_SAMPLE, 0, 0, 16'sd0);
        drain();

        // Same channel through SiLU: zero, positive and negative inputs
        set_config(4, 1, 1);
        send(OP_SAMPLE, 0, 0, 16'sd0);
        send(OP_SAMPLE, 0, 0, 16'sd4096);
        send(OP_SAMPLE, 0, 0, -16'sd4096);
        drain();

        // Random phases, each under its own register setting
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < FIXED_PHASES)
            begin
                k    = PHASE_TAPS[p];
                d    = PHASE_SPACING[p];
                silu = PHASE_SILU[p];
            end
            else
            begin
                k    = $urandom_range(0, 7);
                d    = $urandom_range(0, 7);
                silu = $urandom_range(0, 1);
            end
            set_config(k, d, silu);
            // A long receiver hold-off in a few phases: the output register and
            // the pipeline fill and the block must stall its input
            if (p % 4 == 1) hold_req = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) random_item();
            drain();
        end

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Slowest correct run ends well before this watchdog fires
    initial
    begin : watchdog
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
sv/cdcs_pkg.sv
sv/cdcs_if.sv
sv/cdcs_regs.sv
sv/causal_depthwise_conv_with_state.sv
tb/sv/testbench.sv
